// File: design/mgr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mgr_pkg
// Shared types and constants for the 2-D multigrid restriction block.
// ============================================================================
package mgr_pkg;

    localparam int MAX_FINE_SIZE_DEF = 1025;
    localparam int DATA_WIDTH_DEF    = 32;

    localparam int VALUE_W     = 32;
    localparam int COORD_W     = 10;
    localparam int FINE_SIZE_W = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    localparam int MIN_FINE_SIZE = 5;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTING_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FINE_SIZE      = 1'd1;

    localparam logic MODE_FULL = 1'b0;
    localparam logic MODE_HALF = 1'b1;

    localparam logic [FINE_SIZE_W-1:0] FINE_SIZE_RESET = 11'd1025;

    typedef struct packed {
        logic               interior;
        logic [COORD_W-1:0] crow;
        logic [COORD_W-1:0] ccol;
        logic               done;
    } mgr_ctrl_t;

    localparam int CTRL_W = $bits(mgr_ctrl_t);

endpackage

// File: design/mgr_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// mgr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/mgr_front.sv
`timescale 1ns / 1ps
// ============================================================================
// mgr_front
// Front end: raster counters, point classification, line stores, 3x3 window
// and partial sums; pushes one queue entry per emitted coarse point.
// ============================================================================
module mgr_front
    import mgr_pkg::*;
#(
    parameter int MAX_FINE_SIZE = MAX_FINE_SIZE_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
    localparam int EW      = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W,
    localparam int ENTRY_W = CTRL_W + EW + 2 * (EW + 2)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [VALUE_W-1:0]       fine_value,
    input  logic [FINE_SIZE_W-1:0]   fine_size,
    input  logic                     q_full,
    output logic                     q_push,
    output logic [ENTRY_W-1:0]       q_data
);

    localparam int CW  = $clog2(MAX_FINE_SIZE);
    localparam int SZW = (CW > FINE_SIZE_W) ? CW : FINE_SIZE_W;
    localparam logic [SZW-1:0] TOP_SIZE = SZW'((MAX_FINE_SIZE - 1) | 1);

    logic [SZW-1:0] size_odd;
    logic [SZW-1:0] size_clamped;
    logic [CW-1:0]  n;
    logic [CW-1:0]  nm1;
    logic [CW-1:0]  nm2;

    logic [CW-1:0] row_reg;
    logic [CW-1:0] col_reg;

    logic       accept;
    logic       s1_adv;
    logic       in_grid;
    logic       is_boundary;
    logic       is_interior;
    logic       emit;
    mgr_ctrl_t  ctrl;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    mgr_ctrl_t        s1_ctrl_reg;
    logic [EW-1:0]    s1_x_reg;
    logic [CW-1:0]    s1_col_reg;

    logic [EW-1:0] win_reg [0:5];
    logic [EW-1:0] top_rd;
    logic [EW-1:0] mid_rd;

    logic signed [EW-1:0] ctr;
    logic signed [EW+1:0] edges;
    logic signed [EW+1:0] corners;

    // effective grid side
    always_comb
    begin
        size_odd = SZW'(fine_size) | SZW'(1);
        if (size_odd < SZW'(MIN_FINE_SIZE))
        begin
            size_clamped = SZW'(MIN_FINE_SIZE);
        end
        else if (size_odd > TOP_SIZE)
        begin
            size_clamped = TOP_SIZE;
        end
        else
        begin
            size_clamped = size_odd;
        end
    end

    assign n   = CW'(size_clamped);
    assign nm1 = n - CW'(1);
    assign nm2 = n - CW'(2);

    // classify the incoming sample
    always_comb
    begin
        in_grid     = (row_reg < n) && (col_reg < n);
        is_boundary = !row_reg[0] && !col_reg[0] &&
                      ((row_reg == '0) || (col_reg == '0) ||
                       (row_reg == nm1) || (col_reg == nm1));
        is_interior = row_reg[0] && col_reg[0] &&
                      (row_reg >= CW'(3)) && (col_reg >= CW'(3)) &&
                      (row_reg <= nm2) && (col_reg <= nm2);
        emit          = in_grid && (is_boundary || is_interior);
        ctrl.interior = is_interior;
        ctrl.crow     = COORD_W'(row_reg >> 1);
        ctrl.ccol     = COORD_W'(col_reg >> 1);
        ctrl.done     = (row_reg == nm1) && (col_reg == nm1);
    end

    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !q_full);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    // raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (col_reg >= nm1)
            begin
                col_reg <= '0;
                row_reg <= (row_reg >= nm1) ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= emit;
            s1_ctrl_reg <= ctrl;
            s1_x_reg    <= fine_value[EW-1:0];
            s1_col_reg  <= col_reg;
        end
    end

    mgr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FINE_SIZE)
    ) u_older (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (mid_rd),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (top_rd)
    );

    mgr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FINE_SIZE)
    ) u_newer (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_x_reg),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (mid_rd)
    );

    // shift the window one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top_rd;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid_rd;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_x_reg;
        end
    end

    always_comb
    begin
        ctr     = s1_ctrl_reg.interior ? signed'(win_reg[3]) : signed'(s1_x_reg);
        edges   = (EW+2)'(signed'(win_reg[1])) + (EW+2)'(signed'(win_reg[5]))
                + (EW+2)'(signed'(win_reg[2])) + (EW+2)'(signed'(mid_rd));
        corners = (EW+2)'(signed'(win_reg[0])) + (EW+2)'(signed'(top_rd))
                + (EW+2)'(signed'(win_reg[4])) + (EW+2)'(signed'(s1_x_reg));
    end

    assign q_push = s1_valid_reg && s1_emit_reg && !q_full;
    assign q_data = {s1_ctrl_reg, ctr, edges, corners};

endmodule

// File: design/mgr_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// mgr_queue
// Small register FIFO between the front end and the back end.
// ============================================================================
module mgr_queue
    import mgr_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [0:QUEUE_DEPTH-1];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    rptr_reg;
    logic [NW-1:0]    count_reg;

    assign full      = (count_reg == NW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

// File: design/mgr_back.sv
`timescale 1ns / 1ps
// ============================================================================
// mgr_back
// Back end: final weighting sum, arithmetic shift and output register.
// ============================================================================
module mgr_back
    import mgr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int EW      = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W,
    localparam int ENTRY_W = CTRL_W + EW + 2 * (EW + 2)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 weighting_mode,
    input  logic                 q_not_empty,
    input  logic [ENTRY_W-1:0]   q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [VALUE_W-1:0]   coarse_value,
    output logic [COORD_W-1:0]   coarse_row,
    output logic [COORD_W-1:0]   coarse_col,
    output logic                 grid_done
);

    localparam int SUMW = EW + 5;

    mgr_ctrl_t            ctrl;
    logic signed [EW-1:0] ctr;
    logic signed [EW+1:0] edges;
    logic signed [EW+1:0] corners;

    logic signed [SUMW-1:0] sum_full;
    logic signed [SUMW-1:0] sum_half;
    logic signed [SUMW-1:0] shifted;
    logic signed [EW-1:0]   result;

    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [COORD_W-1:0]   row_reg;
    logic [COORD_W-1:0]   col_reg;
    logic                 done_reg;

    assign {ctrl, ctr, edges, corners} = q_head;

    always_comb
    begin
        sum_full = (SUMW'(ctr) <<< 2) + (SUMW'(edges) <<< 1) + SUMW'(corners);
        sum_half = (SUMW'(ctr) <<< 2) + SUMW'(edges);
        case (weighting_mode)
            MODE_FULL: shifted = sum_full >>> 4;
            MODE_HALF: shifted = sum_half >>> 3;
            default:   shifted = sum_full >>> 4;
        endcase
        result = ctrl.interior ? shifted[EW-1:0] : ctr;
    end

    assign q_pop = q_not_empty && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            value_reg <= VALUE_W'(result);
            row_reg   <= ctrl.crow;
            col_reg   <= ctrl.ccol;
            done_reg  <= ctrl.done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coarse_value = value_reg;
    assign coarse_row   = row_reg;
    assign coarse_col   = col_reg;
    assign grid_done    = done_reg;

endmodule

// File: design/multigrid_restriction_2d.sv
`timescale 1ns / 1ps
// ============================================================================
// multigrid_restriction_2d
// Full/half weighting restriction of a raster fine grid onto its coarse grid.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  fine_value
//   out      source     out_valid/out_stall  coarse_value, coarse_row,
//                                            coarse_col, grid_done
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// One fine sample per cycle sustained while the output is not stalled;
// the line-store read and the window shift each happen once per sample.
// An input transaction loads the front stage at its accepting edge, then
// the queue, and then the output register, which raises out_valid.
// Reset clears counters, window and handshake state; line stores hold no
// meaning until written and need no clearing pass.
// A stalled output fills the two-entry queue, then holds the front stage
// and raises in_stall.
// ============================================================================
module multigrid_restriction_2d
    import mgr_pkg::*;
#(
    parameter int MAX_FINE_SIZE = MAX_FINE_SIZE_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_W-1:0]     fine_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [VALUE_W-1:0]     coarse_value,
    output logic [COORD_W-1:0]     coarse_row,
    output logic [COORD_W-1:0]     coarse_col,
    output logic                   grid_done
);

    localparam int EW      = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int ENTRY_W = CTRL_W + EW + 2 * (EW + 2);

    logic                   mode_reg;
    logic [FINE_SIZE_W-1:0] size_reg;

    logic               q_push;
    logic [ENTRY_W-1:0] q_data;
    logic               q_full;
    logic               q_pop;
    logic               q_not_empty;
    logic [ENTRY_W-1:0] q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FULL;
            size_reg <= FINE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WEIGHTING_MODE: mode_reg <= cfg_data[0];
                REG_FINE_SIZE:      size_reg <= cfg_data[FINE_SIZE_W-1:0];
                default:            ;
            endcase
        end
    end

    mgr_front #(
        .MAX_FINE_SIZE (MAX_FINE_SIZE),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .fine_value (fine_value),
        .fine_size  (size_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    mgr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mgr_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .weighting_mode (mode_reg),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .coarse_value   (coarse_value),
        .coarse_row     (coarse_row),
        .coarse_col     (coarse_col),
        .grid_done      (grid_done)
    );

endmodule

// File: design/mgr_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mgr_checker
// Port-level checks for the multigrid restriction block, bound to the top.
// ============================================================================
module mgr_checker
    import mgr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [VALUE_W-1:0] coarse_value,
    input logic [COORD_W-1:0] coarse_row,
    input logic [COORD_W-1:0] coarse_col,
    input logic               grid_done
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(coarse_value) &&
        $stable(coarse_row) && $stable(coarse_col) && $stable(grid_done))
        else $error("stalled output transaction changed");

    // the last point of a grid is its far corner
    a_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grid_done |-> coarse_row == coarse_col)
        else $error("grid_done away from the diagonal corner");

    // nothing is in flight right after reset
    a_reset_free: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_stall && !out_valid)
        else $error("busy right after reset");

    // a stall needs an accepted transaction still held in the front stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(in_valid && !in_stall) || $past(in_stall))
        else $error("input stalled with no transaction in flight");

endmodule

bind multigrid_restriction_2d mgr_checker u_mgr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coarse_value (coarse_value),
    .coarse_row   (coarse_row),
    .coarse_col   (coarse_col),
    .grid_done    (grid_done)
);

// File: dv/mgr_restriction_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mgr_restriction_checker
// Watches the configuration port and both channels of the 2-D multigrid
// restriction block. Keeps its own copy of the line stores, the 3x3 window
// and the raster counters, works out the coarse point that each accepted
// fine sample produces, and compares every accepted result in order
// against the oldest pending point.
// ============================================================================
module mgr_restriction_checker
    import mgr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [VALUE_W-1:0]     fine_value,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [VALUE_W-1:0]     coarse_value,
    input  logic [COORD_W-1:0]     coarse_row,
    input  logic [COORD_W-1:0]     coarse_col,
    input  logic                   grid_done,
    output int                     failures,
    output int                     outstanding,
    output int                     samples_seen,
    output int                     results_seen
);

    localparam int STORE_DEPTH = MAX_FINE_SIZE_DEF;
    localparam int TOP_SIZE    = (STORE_DEPTH - 1) | 1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               done;
    } coarse_point_t;

    coarse_point_t             coarse_q [$];
    logic signed [VALUE_W-1:0] row_older [STORE_DEPTH];
    logic signed [VALUE_W-1:0] row_newer [STORE_DEPTH];
    logic signed [VALUE_W-1:0] win [6];
    logic                      mode;
    logic [FINE_SIZE_W-1:0]    size_reg;
    int unsigned               frow;
    int unsigned               fcol;

    always @(posedge clk or negedge rst_n) begin : predict
        int unsigned               n;
        int unsigned               r;
        int unsigned               c;
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] top;
        logic signed [VALUE_W-1:0] mid;
        longint                    ctr;
        longint                    edges;
        longint                    corners;
        longint                    acc;
        logic                      emit;
        coarse_point_t             got;
        coarse_point_t             want;
        if (!rst_n)
        begin
            mode     = MODE_FULL;
            size_reg = FINE_SIZE_RESET;
            frow     = 0;
            fcol     = 0;
            foreach (win[i])
                win[i] = '0;
            foreach (row_older[i])
            begin
                row_older[i] = '0;
                row_newer[i] = '0;
            end
            coarse_q.delete();
            failures     <= 0;
            outstanding  <= 0;
            samples_seen <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WEIGHTING_MODE)
                    mode = cfg_data[0];
                else if (cfg_index == REG_FINE_SIZE)
                    size_reg = cfg_data[FINE_SIZE_W-1:0];
            end

            if (out_valid && !out_stall)
            begin
                got = {coarse_value, coarse_row, coarse_col, grid_done};
                results_seen <= results_seen + 1;
                if (coarse_q.size() == 0)
                begin
                    $display("%0t: unexpected result: value=%h row=%0d col=%0d done=%0b",
                             $time, got.value, got.row, got.col, got.done);
                    failures <= failures + 1;
                end
                else
                begin
                    want = coarse_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch: expected value=%h row=%0d col=%0d done=%0b",
                                 $time, want.value, want.row, want.col, want.done);
                        $display("%0t:           actual   value=%h row=%0d col=%0d done=%0b",
                                 $time, got.value, got.row, got.col, got.done);
                        failures <= failures + 1;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                n = size_reg | 1;
                if (n < MIN_FINE_SIZE)
                    n = MIN_FINE_SIZE;
                if (n > TOP_SIZE)
                    n = TOP_SIZE;
                r    = frow;
                c    = fcol;
                x    = fine_value;
                top  = '0;
                mid  = '0;
                emit = 1'b0;
                want = '0;
                if (c < STORE_DEPTH)
                begin
                    top = row_older[c];
                    mid = row_newer[c];
                end

                if (r < n && c < n)
                begin
                    if ((r & 1) == 0 && (c & 1) == 0
                        && (r == 0 || c == 0 || r == n - 1 || c == n - 1))
                    begin
                        emit       = 1'b1;
                        want.value = x;
                        want.row   = COORD_W'(r >> 1);
                        want.col   = COORD_W'(c >> 1);
                    end
                    else if ((r & 1) == 1 && (c & 1) == 1
                             && r >= 3 && c >= 3 && r <= n - 2 && c <= n - 2)
                    begin
                        ctr     = win[3];
                        edges   = longint'(win[1]) + win[5] + win[2] + mid;
                        corners = longint'(win[0]) + top + win[4] + x;
                        if (mode == MODE_FULL)
                            acc = (4 * ctr + 2 * edges + corners) >>> 4;
                        else
                            acc = (4 * ctr + edges) >>> 3;
                        emit       = 1'b1;
                        want.value = VALUE_W'(acc);
                        want.row   = COORD_W'((r - 1) >> 1);
                        want.col   = COORD_W'((c - 1) >> 1);
                    end
                    want.done = (r == n - 1) && (c == n - 1);
                end

                win[0] = win[1];
                win[1] = top;
                win[2] = win[3];
                win[3] = mid;
                win[4] = win[5];
                win[5] = x;
                if (c < STORE_DEPTH)
                begin
                    row_older[c] = mid;
                    row_newer[c] = x;
                end
                if (emit)
                    coarse_q.push_back(want);

                if (c >= n - 1)
                begin
                    fcol = 0;
                    frow = (r >= n - 1) ? 0 : r + 1;
                end
                else
                begin
                    fcol = c + 1;
                end
                samples_seen <= samples_seen + 1;
            end
            outstanding <= coarse_q.size();
        end
    end

endmodule

// File: dv/tb_multigrid_restriction_2d.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_multigrid_restriction_2d
// Stimulus and verdict for the 2-D multigrid restriction block. Feeds a
// saturated 5x5 grid, two full rows of a 17-wide grid, a stretch of the
// largest grid and a shrink to the smallest one mid-grid, then random grids
// of small sizes in both weighting modes, some cut short so the next size
// lands mid-grid. Both channels idle at random, the receiver holds off once
// for a long stretch, and a separate checker predicts and compares every
// coarse point.
// ============================================================================
module tb_multigrid_restriction_2d;
    import mgr_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 5000;
    localparam int RANDOM_ITEMS    = 600;
    localparam int WIDE_SIZE       = 17;
    localparam int LARGE_PREFIX    = 20;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [VALUE_W-1:0]     fine_value   = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [VALUE_W-1:0]     coarse_value;
    logic [COORD_W-1:0]     coarse_row;
    logic [COORD_W-1:0]     coarse_col;
    logic                   grid_done;

    int   failures;
    int   outstanding;
    int   samples_seen;
    int   results_seen;
    int   sender_idle_pct   = 32;
    int   receiver_idle_pct = 57;
    logic hold_req          = 1'b0;
    int   quiet_cycles      = 0;

    always #5 clk = ~clk;

    multigrid_restriction_2d uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .fine_value   (fine_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coarse_value (coarse_value),
        .coarse_row   (coarse_row),
        .coarse_col   (coarse_col),
        .grid_done    (grid_done)
    );

    mgr_restriction_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .fine_value   (fine_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coarse_value (coarse_value),
        .coarse_row   (coarse_row),
        .coarse_col   (coarse_col),
        .grid_done    (grid_done),
        .failures     (failures),
        .outstanding  (outstanding),
        .samples_seen (samples_seen),
        .results_seen (results_seen)
    );

    always @(negedge clk) begin : receiver
        int hold_left;
        bit hold_taken;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_OFF_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_multigrid_restriction_2d: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return VALUE_W'(int'($urandom_range(255)) - 128);
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        fine_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial begin : stimulus
        int                     i;
        int                     used;
        int                     count;
        int                     fed;
        int                     phase;
        logic [FINE_SIZE_W-1:0] raw;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // saturated neighbourhood around the one interior point, extreme boundaries
        write_reg(REG_WEIGHTING_MODE, CFG_DATA_W'(MODE_FULL));
        write_reg(REG_FINE_SIZE, CFG_DATA_W'(5));
        for (i = 0; i < 25; i++)
            push_sample((i / 5 >= 1 && i / 5 <= 3 && i % 5 >= 1 && i % 5 <= 3) ? 32'h7FFF_FFFF :
                        (i == 24) ? 32'hFFFF_FFFF :
                        (i == 2)  ? 32'h0000_0000 : 32'h8000_0000);

        // fill every column the random grids use, visit the largest grid,
        // then shrink to the smallest size mid-grid
        settle();
        write_reg(REG_WEIGHTING_MODE, CFG_DATA_W'(MODE_HALF));
        write_reg(REG_FINE_SIZE, CFG_DATA_W'(WIDE_SIZE));
        repeat (2 * WIDE_SIZE) push_sample(pick_value());
        settle();
        write_reg(REG_FINE_SIZE, CFG_DATA_W'(11'h7FF));
        repeat (LARGE_PREFIX) push_sample(pick_value());
        settle();
        write_reg(REG_FINE_SIZE, CFG_DATA_W'(0));
        repeat (11) push_sample(pick_value());

        fed   = 0;
        phase = 0;
        while (fed < RANDOM_ITEMS)
        begin
            settle();
            if (fed >= 2 * RANDOM_ITEMS / 3)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct <= 0;
            end
            else if (fed >= RANDOM_ITEMS / 3)
            begin
                sender_idle_pct   = 57;
                receiver_idle_pct <= 32;
            end
            raw = FINE_SIZE_W'($urandom_range(WIDE_SIZE));
            if (phase == 2)
            begin
                hold_req <= 1'b1;
                raw = FINE_SIZE_W'(WIDE_SIZE);
            end
            write_reg(REG_WEIGHTING_MODE, CFG_DATA_W'($urandom_range(1)));
            write_reg(REG_FINE_SIZE, CFG_DATA_W'(raw));
            used = raw | 1;
            if (used < MIN_FINE_SIZE)
                used = MIN_FINE_SIZE;
            count = used * used;
            if ($urandom_range(3) == 0)
                count = $urandom_range(count, 1);
            repeat (count) push_sample(pick_value());
            fed += count;
            phase++;
        end

        settle();
        $display("run covered %0d fine samples and %0d coarse points, %0d failures",
                 samples_seen, results_seen, failures);
        $display("both weightings, sizes 5 to 1025 incl. clamped and even codes, mid-grid resize");
        if (failures == 0)
            $display("tb_multigrid_restriction_2d: clean");
        else
            $display("tb_multigrid_restriction_2d: errors");
        $finish;
    end

endmodule
